FILE: src/sfb_pkg.sv
// shared constants, types and the crc-8 byte step for the sensor frame builder
`default_nettype none
package sfb_pkg;

   localparam int FRAME_LEN   = 17;
   localparam int CRC_SPAN    = 16;
   localparam int FRAME_CNT_W = $clog2(FRAME_LEN);

   localparam logic [7:0] START_BYTE     = 8'hCC;
   localparam logic [7:0] LENGTH_BYTE    = 8'd13;
   localparam logic [7:0] TYPE_BYTE      = 8'hF5;
   localparam logic [7:0] CRC_POLY       = 8'h31;
   localparam logic [7:0] SENSOR_ID_INIT = 8'd3;

   typedef logic [CRC_SPAN-1:0][7:0] frame_type;

   typedef struct packed {
      frame_type  bytes;
      logic [7:0] crc;
   } frame_crc_type;

   function automatic logic [7:0] crc8_byte(input logic [7:0] acc_i, input logic [7:0] data_i);
      logic [7:0] acc;
      logic [7:0] data;
      logic       top;
      acc  = acc_i;
      data = data_i;
      for (int b = 0; b < 8; b++) begin
         top  = acc[7] ^ data[7];
         acc  = {acc[6:0], 1'b0} ^ (top ? CRC_POLY : 8'h00);
         data = {data[6:0], 1'b0};
      end
      return acc;
   endfunction

endpackage
`default_nettype wire

FILE: src/sfb_crc_stage.sv
// one pipeline stage: folds one frame byte into the running crc
`default_nettype none
module sfb_crc_stage
   import sfb_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          up_valid,
   output logic               up_ready,
   input  wire frame_crc_type up_data,
   input  wire logic [7:0]    up_byte,
   output logic               dn_valid,
   input  wire logic          dn_ready,
   output frame_crc_type      dn_data
);

   logic          valid_ff;
   frame_crc_type data_ff;
   frame_crc_type data_in;

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   always_comb begin
      data_in       = up_data;
      data_in.crc   = crc8_byte(up_data.crc, up_byte);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/sfb_serializer.sv
// frame shift register: 16 bytes and the crc, one word per cycle unless stalled
`default_nettype none
module sfb_serializer
   import sfb_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          up_valid,
   output logic               up_ready,
   input  wire frame_crc_type up_data,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [7:0]         rsp_frame_byte,
   output logic               rsp_last_byte
);

   logic                       busy_ff;
   logic [FRAME_CNT_W-1:0]     cnt_ff;
   logic [FRAME_LEN-1:0][7:0]  shift_ff;
   logic                       fire;
   logic                       last;
   logic                       load;

   assign last     = (cnt_ff == FRAME_CNT_W'(FRAME_LEN - 1));
   assign fire     = busy_ff && !rsp_stall;
   assign up_ready = !busy_ff || (fire && last);
   assign load     = up_valid && up_ready;

   assign rsp_valid      = busy_ff;
   assign rsp_frame_byte = shift_ff[0];
   assign rsp_last_byte  = busy_ff && last;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (fire) begin
         busy_ff <= !last;
         cnt_ff  <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         shift_ff <= {up_data.crc, up_data.bytes};
      end else if (fire) begin
         shift_ff <= shift_ff >> 8;
      end
   end

`ifndef SYNTHESIS
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      fire && !last |=> rsp_valid)
      else $error("frame has a gap");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      fire && !last && !load |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("byte count skipped");
   a_load_start: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid && !rsp_last_byte && cnt_ff == '0)
      else $error("new frame does not start at its first word");
`endif

endmodule
`default_nettype wire

FILE: src/sensor_frame_builder_crc8_top.sv
// Sensor frame builder: one reading set in, a 17-word radio frame with crc-8 out.
// req_ channel: one word carries a full set of sensor readings; taken at a rising
//    edge with req_valid high and req_stall low.
// rsp_ channel: one frame byte per word, rsp_last_byte marks the trailing crc;
//    taken at a rising edge with rsp_valid high and rsp_stall low.
// csr_ port: csr_wr_en writes csr_wr_data into the sensor id at the rising edge.
// Frame: 0xCC, sensor id, 13, 0xF5, pressure, temperature, humidity, pm fine,
//    pm coarse (all MSB first), battery, crc-8 (poly 0x31, init 0) over 16 bytes.
// The crc runs through a 16-stage pipeline, one frame byte per stage, into a
//    17-byte shift register. The readings of a frame pass through all the stages
//    and are loaded into the shift register before the frame's first byte shows;
//    the sustained rate is set by the output, one byte per cycle while rsp_stall
//    is low, and the next frame is loaded as the last byte of a frame is taken.
// Readings are taken every cycle while pipeline stages are free: up to 17 sets
//    may be held before req_stall rises.
// Reset empties the pipeline and the shift register and sets the sensor id to 3.
// A stall on rsp_ holds the current byte; the pipeline fills behind it and then
//    stalls req_, nothing is lost or repeated.
`default_nettype none
module sensor_frame_builder_crc8_top
   import sfb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [23:0] req_pressure_raw,
   input  wire logic [15:0] req_temperature_raw,
   input  wire logic [15:0] req_humidity_raw,
   input  wire logic [15:0] req_pm_fine,
   input  wire logic [15:0] req_pm_coarse,
   input  wire logic [7:0]  req_battery_level,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_frame_byte,
   output logic             rsp_last_byte,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data
);

   logic [7:0]    sensor_id_ff;
   logic          st_valid [0:CRC_SPAN];
   logic          st_ready [0:CRC_SPAN];
   frame_crc_type st_data  [0:CRC_SPAN];

   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_id_ff <= SENSOR_ID_INIT;
      end else if (csr_wr_en) begin
         sensor_id_ff <= csr_wr_data;
      end
   end

   always_comb begin
      st_data[0].bytes[0]  = START_BYTE;
      st_data[0].bytes[1]  = sensor_id_ff;
      st_data[0].bytes[2]  = LENGTH_BYTE;
      st_data[0].bytes[3]  = TYPE_BYTE;
      st_data[0].bytes[4]  = req_pressure_raw[23:16];
      st_data[0].bytes[5]  = req_pressure_raw[15:8];
      st_data[0].bytes[6]  = req_pressure_raw[7:0];
      st_data[0].bytes[7]  = req_temperature_raw[15:8];
      st_data[0].bytes[8]  = req_temperature_raw[7:0];
      st_data[0].bytes[9]  = req_humidity_raw[15:8];
      st_data[0].bytes[10] = req_humidity_raw[7:0];
      st_data[0].bytes[11] = req_pm_fine[15:8];
      st_data[0].bytes[12] = req_pm_fine[7:0];
      st_data[0].bytes[13] = req_pm_coarse[15:8];
      st_data[0].bytes[14] = req_pm_coarse[7:0];
      st_data[0].bytes[15] = req_battery_level;
      st_data[0].crc       = 8'h00;
   end

   assign st_valid[0] = req_valid;
   assign req_stall   = !st_ready[0];

   for (genvar k = 0; k < CRC_SPAN; k++) begin : g_crc
      sfb_crc_stage u_stage (
         .clock    (clock),
         .reset    (reset),
         .up_valid (st_valid[k]),
         .up_ready (st_ready[k]),
         .up_data  (st_data[k]),
         .up_byte  (st_data[k].bytes[k]),
         .dn_valid (st_valid[k+1]),
         .dn_ready (st_ready[k+1]),
         .dn_data  (st_data[k+1])
      );
   end

   sfb_serializer u_serializer (
      .clock          (clock),
      .reset          (reset),
      .up_valid       (st_valid[CRC_SPAN]),
      .up_ready       (st_ready[CRC_SPAN]),
      .up_data        (st_data[CRC_SPAN]),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

endmodule
`default_nettype wire

FILE: tb/sv/tb_sensor_frame_builder_crc8_top.sv
// self-checking testbench for the sensor frame builder: readings in, checked crc-8 frames out
`default_nettype none
module tb_sensor_frame_builder_crc8_top
   import sfb_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [23:0] pressure_raw;
      logic [15:0] temperature_raw;
      logic [15:0] humidity_raw;
      logic [15:0] pm_fine;
      logic [15:0] pm_coarse;
      logic [7:0]  battery_level;
   } reading_set_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } frame_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [23:0] req_pressure_raw = '0;
   logic [15:0] req_temperature_raw = '0;
   logic [15:0] req_humidity_raw = '0;
   logic [15:0] req_pm_fine = '0;
   logic [15:0] req_pm_coarse = '0;
   logic [7:0]  req_battery_level = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_frame_byte;
   logic        rsp_last_byte;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = '0;

   reading_set_type pending_sets[$];
   reading_set_type held_set;
   frame_word_type  frame_due[$];
   logic [7:0]   sensor_id_now = SENSOR_ID_INIT;
   int           req_gap_max = 0;
   int           rsp_hold_max = 0;
   int           gap_left = 0;
   int           hold_left = 0;
   int           fail_count = 0;
   int           sets_taken = 0;
   int           words_checked = 0;
   int           id_settings = 1;
   int           cycle_count = 0;

   sensor_frame_builder_crc8_top u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_pressure_raw    (req_pressure_raw),
      .req_temperature_raw (req_temperature_raw),
      .req_humidity_raw    (req_humidity_raw),
      .req_pm_fine         (req_pm_fine),
      .req_pm_coarse       (req_pm_coarse),
      .req_battery_level   (req_battery_level),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_frame_byte      (rsp_frame_byte),
      .rsp_last_byte       (rsp_last_byte),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // builds the 17-byte frame for one reading set and queues it word by word
   function automatic void queue_frame(input reading_set_type rs);
      logic [7:0]     fr [FRAME_LEN];
      logic [7:0]     acc;
      logic           fb;
      frame_word_type w;
      fr[0]  = START_BYTE;
      fr[1]  = sensor_id_now;
      fr[2]  = LENGTH_BYTE;
      fr[3]  = TYPE_BYTE;
      fr[4]  = rs.pressure_raw[23:16];
      fr[5]  = rs.pressure_raw[15:8];
      fr[6]  = rs.pressure_raw[7:0];
      fr[7]  = rs.temperature_raw[15:8];
      fr[8]  = rs.temperature_raw[7:0];
      fr[9]  = rs.humidity_raw[15:8];
      fr[10] = rs.humidity_raw[7:0];
      fr[11] = rs.pm_fine[15:8];
      fr[12] = rs.pm_fine[7:0];
      fr[13] = rs.pm_coarse[15:8];
      fr[14] = rs.pm_coarse[7:0];
      fr[15] = rs.battery_level;
      acc = 8'h00;
      for (int k = 0; k < CRC_SPAN; k++) begin
         for (int b = 7; b >= 0; b--) begin
            fb  = acc[7] ^ fr[k][b];
            acc = {acc[6:0], 1'b0};
            if (fb) begin
               acc = acc ^ CRC_POLY;
            end
         end
      end
      fr[FRAME_LEN-1] = acc;
      for (int k = 0; k < FRAME_LEN; k++) begin
         w.frame_byte = fr[k];
         w.last_byte  = (k == FRAME_LEN - 1);
         frame_due.push_back(w);
      end
   endfunction

   function automatic reading_set_type random_set();
      reading_set_type rs;
      rs.pressure_raw    = 24'($urandom());
      rs.temperature_raw = 16'($urandom());
      rs.humidity_raw    = 16'($urandom());
      rs.pm_fine         = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom());
      rs.pm_coarse       = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom());
      rs.battery_level   = 8'($urandom());
      return rs;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            queue_frame(held_set);
            sets_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_sets.size() > 0) begin
               held_set             = pending_sets.pop_front();
               req_pressure_raw    <= held_set.pressure_raw;
               req_temperature_raw <= held_set.temperature_raw;
               req_humidity_raw    <= held_set.humidity_raw;
               req_pm_fine         <= held_set.pm_fine;
               req_pm_coarse       <= held_set.pm_coarse;
               req_battery_level   <= held_set.battery_level;
               req_valid           <= 1'b1;
               gap_left            <= $urandom_range(0, req_gap_max);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin
      int             n;
      frame_word_type w;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (frame_due.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual byte %02h last %0b",
                     $time, rsp_frame_byte, rsp_last_byte);
            fail_count++;
         end else begin
            w = frame_due.pop_front();
            if (rsp_frame_byte !== w.frame_byte) begin
               $display("%0t: frame_byte expected %02h actual %02h",
                        $time, w.frame_byte, rsp_frame_byte);
               fail_count++;
            end
            if (rsp_last_byte !== w.last_byte) begin
               $display("%0t: last_byte expected %0b actual %0b",
                        $time, w.last_byte, rsp_last_byte);
               fail_count++;
            end
         end
         words_checked++;
         n = $urandom_range(0, rsp_hold_max);
         hold_left <= n;
         rsp_stall <= (n != 0);
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= (hold_left > 1);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sensor_frame_builder_crc8_top: mismatch");
         $finish;
      end
   end

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_sets.size() != 0 || req_valid || frame_due.size() != 0);
   endtask

   task automatic write_sensor_id(input logic [7:0] id);
      @(posedge clock);
      csr_wr_en     <= 1'b1;
      csr_wr_data   <= id;
      sensor_id_now  = id;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      id_settings++;
   endtask

   task automatic add_set(input logic [23:0] p, input logic [15:0] t, input logic [15:0] h,
                          input logic [15:0] f, input logic [15:0] c, input logic [7:0] b);
      reading_set_type rs;
      rs = '{p, t, h, f, c, b};
      pending_sets.push_back(rs);
   endtask

   task automatic run_random(input int count, input int gap_max, input int hold_max);
      req_gap_max  = gap_max;
      rsp_hold_max = hold_max;
      repeat (count) pending_sets.push_back(random_set());
      wait_idle();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset sensor id, back to back with no idling
      add_set(24'h000000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      add_set(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
      add_set(24'hAAAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 8'hAA);
      add_set(24'h555555, 16'h5555, 16'h5555, 16'h5555, 16'h5555, 8'h55);
      add_set(24'h800000, 16'h8000, 16'h0001, 16'hFFFF, 16'h1234, 8'h80);
      add_set(24'h000001, 16'h7FFF, 16'h8000, 16'h00FA, 16'hFFFF, 8'h01);
      add_set(24'h123456, 16'h0C80, 16'h2710, 16'hFFFF, 16'hFFFF, 8'h7F);
      run_random(0, 0, 0);

      write_sensor_id(8'hFF);
      add_set(24'hFFFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 8'h00);
      add_set(24'h000000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 8'hFF);
      run_random(40, 9, 9);

      write_sensor_id(8'h00);
      add_set(24'h0F0F0F, 16'hF0F0, 16'h0F0F, 16'hFFFF, 16'hFFFF, 8'hC3);
      add_set(24'h000000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      run_random(40, 0, 9);

      write_sensor_id(8'($urandom()));
      run_random(50, 9, 0);

      write_sensor_id(8'($urandom()));
      run_random(50, 9, 9);

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d reading sets and %0d frame words over %0d sensor id settings",
               sets_taken, words_checked, id_settings);
      $display("including all-zero, all-one and invalid particulate readings, with idling");
      if (fail_count == 0) begin
         $display("sensor_frame_builder_crc8_top: match");
      end else begin
         $display("sensor_frame_builder_crc8_top: mismatch");
      end
      $finish;
   end

endmodule
`default_nettype wire
